// ===== hdl/rip_pkg.sv =====
// Shared types, constants and guard tables for the radix int64 parser.
package rip_pkg;

  // Character codes
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] CHAR_DIG0  = 8'h30;
  localparam logic [7:0] CHAR_DIG9  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;

  // Radix register
  localparam int unsigned RADIX_W     = 5;
  localparam logic [4:0]  RADIX_RESET = 5'd10;
  localparam logic [4:0]  RADIX_MIN   = 5'd2;
  localparam logic [4:0]  RADIX_MAX   = 5'd16;

  // Queue depths
  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // Accumulation limits: the value is gathered as a negative number
  localparam logic signed [63:0] LIMIT_NEG = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] LIMIT_POS = -64'sh7FFF_FFFF_FFFF_FFFF;

  // Largest magnitude that may still be multiplied by the radix, per radix
  localparam logic signed [63:0] GUARD_NEG [0:16] = '{
    64'sd0, 64'sd0,
    LIMIT_NEG / 64'sd2,  LIMIT_NEG / 64'sd3,  LIMIT_NEG / 64'sd4,
    LIMIT_NEG / 64'sd5,  LIMIT_NEG / 64'sd6,  LIMIT_NEG / 64'sd7,
    LIMIT_NEG / 64'sd8,  LIMIT_NEG / 64'sd9,  LIMIT_NEG / 64'sd10,
    LIMIT_NEG / 64'sd11, LIMIT_NEG / 64'sd12, LIMIT_NEG / 64'sd13,
    LIMIT_NEG / 64'sd14, LIMIT_NEG / 64'sd15, LIMIT_NEG / 64'sd16
  };
  localparam logic signed [63:0] GUARD_POS [0:16] = '{
    64'sd0, 64'sd0,
    LIMIT_POS / 64'sd2,  LIMIT_POS / 64'sd3,  LIMIT_POS / 64'sd4,
    LIMIT_POS / 64'sd5,  LIMIT_POS / 64'sd6,  LIMIT_POS / 64'sd7,
    LIMIT_POS / 64'sd8,  LIMIT_POS / 64'sd9,  LIMIT_POS / 64'sd10,
    LIMIT_POS / 64'sd11, LIMIT_POS / 64'sd12, LIMIT_POS / 64'sd13,
    LIMIT_POS / 64'sd14, LIMIT_POS / 64'sd15, LIMIT_POS / 64'sd16
  };

  // Character class decided by the front
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_MINUS = 2'd1,
    CLS_DIGIT = 2'd2,
    CLS_BAD   = 2'd3
  } cls_t;

  // Parse phase
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } out_word_t;

  // Classified word between front and back
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic [4:0] base;
    logic       last;
  } mid_word_t;

  // Finished text: raw negative accumulator, sign and status
  typedef struct packed {
    logic signed [63:0] acc;
    logic               neg;
    logic               ok;
  } res_word_t;

endpackage

// ===== hdl/rip_fifo.sv =====
// Small register queue with registered storage, used for the classified queue and the result queue.
module rip_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/rip_front.sv =====
// Front stage: holds the radix, accepts characters and classifies them.
module rip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic                in_push,
  input  rip_pkg::in_word_t   in_word,
  input  logic                mid_full,
  output logic                mid_push,
  output rip_pkg::mid_word_t  mid_word
);

  logic [4:0] radix_r, radix_nxt;
  logic [4:0] base_w;
  logic [7:0] diff_w;
  logic [3:0] dig_w;
  logic       is_dig_w;

  // Hold the radix register
  always_comb begin
    radix_nxt = cfg_we ? cfg_data : radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rip_pkg::RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // Clamp radix to the supported range
  always_comb begin
    if (radix_r < rip_pkg::RADIX_MIN) begin
      base_w = rip_pkg::RADIX_MIN;
    end else if (radix_r > rip_pkg::RADIX_MAX) begin
      base_w = rip_pkg::RADIX_MAX;
    end else begin
      base_w = radix_r;
    end
  end

  // Decode the character into a digit value
  always_comb begin
    diff_w   = '0;
    dig_w    = '0;
    is_dig_w = 1'b0;
    case (in_word.char_code) inside
      [rip_pkg::CHAR_DIG0:rip_pkg::CHAR_DIG9]: begin
        diff_w   = in_word.char_code - rip_pkg::CHAR_DIG0;
        dig_w    = diff_w[3:0];
        is_dig_w = 1'b1;
      end
      [rip_pkg::CHAR_UP_A:rip_pkg::CHAR_UP_F]: begin
        diff_w   = in_word.char_code - rip_pkg::CHAR_UP_A;
        dig_w    = diff_w[3:0] + 4'd10;
        is_dig_w = 1'b1;
      end
      [rip_pkg::CHAR_LO_A:rip_pkg::CHAR_LO_F]: begin
        diff_w   = in_word.char_code - rip_pkg::CHAR_LO_A;
        dig_w    = diff_w[3:0] + 4'd10;
        is_dig_w = 1'b1;
      end
      default: begin
        is_dig_w = 1'b0;
      end
    endcase
  end

  // Classify and forward; drop idle words
  always_comb begin
    mid_word.digit = dig_w;
    mid_word.base  = base_w;
    mid_word.last  = in_word.last;
    if (!in_word.has_char) begin
      mid_word.cls = rip_pkg::CLS_NONE;
    end else if (in_word.char_code == rip_pkg::MINUS_CHAR) begin
      mid_word.cls = rip_pkg::CLS_MINUS;
    end else if (!is_dig_w || ({1'b0, dig_w} >= base_w)) begin
      mid_word.cls = rip_pkg::CLS_BAD;
    end else begin
      mid_word.cls = rip_pkg::CLS_DIGIT;
    end
    mid_push = in_push && !mid_full && (in_word.has_char || in_word.last);
  end

endmodule

// ===== hdl/rip_back.sv =====
// Back stage: accumulates digits with overflow guards and emits finished texts.
module rip_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_empty,
  input  rip_pkg::mid_word_t  mid_word,
  output logic                mid_pop,
  input  logic                res_full,
  output logic                res_push,
  output rip_pkg::res_word_t  res_word
);

  logic signed [63:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               failed_r, failed_nxt;
  rip_pkg::phase_t    phase_r, phase_nxt;

  logic signed [63:0] guard_w;
  logic signed [63:0] limit_w;
  logic signed [68:0] prod_w;
  logic signed [64:0] step_w;
  logic signed [64:0] limit_ext_w;

  // Pop when a word waits and a final word has room downstream
  assign mid_pop  = !mid_empty && (!mid_word.last || !res_full);
  assign res_push = mid_pop && mid_word.last;

  // Guard, limit and multiply-subtract for one digit step
  always_comb begin
    guard_w     = neg_r ? rip_pkg::GUARD_NEG[mid_word.base]
                        : rip_pkg::GUARD_POS[mid_word.base];
    limit_w     = neg_r ? rip_pkg::LIMIT_NEG : rip_pkg::LIMIT_POS;
    prod_w      = acc_r * $signed({1'b0, mid_word.base});
    step_w      = $signed(prod_w[64:0]) - $signed({61'd0, mid_word.digit});
    limit_ext_w = {limit_w[63], limit_w};
  end

  // Advance the parse state for the popped word
  always_comb begin
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    failed_nxt = failed_r;
    phase_nxt  = phase_r;
    if (mid_pop && (mid_word.cls != rip_pkg::CLS_NONE) && !failed_r) begin
      if ((phase_r == rip_pkg::PH_START) && (mid_word.cls == rip_pkg::CLS_MINUS)) begin
        neg_nxt   = 1'b1;
        phase_nxt = rip_pkg::PH_SIGN;
      end else if (mid_word.cls != rip_pkg::CLS_DIGIT) begin
        failed_nxt = 1'b1;
      end else begin
        case (phase_r)
          rip_pkg::PH_START, rip_pkg::PH_SIGN: begin
            acc_nxt   = -$signed({60'd0, mid_word.digit});
            phase_nxt = rip_pkg::PH_DIGITS;
          end
          default: begin
            if (acc_r < guard_w) begin
              failed_nxt = 1'b1;
            end else if (step_w < limit_ext_w) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt = step_w[63:0];
            end
          end
        endcase
      end
    end
    // Emit the finished text from the updated state
    res_word.acc = acc_nxt;
    res_word.neg = neg_nxt;
    res_word.ok  = !failed_nxt && (phase_nxt == rip_pkg::PH_DIGITS);
    // Clear for the next text
    if (res_push) begin
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      failed_nxt = 1'b0;
      phase_nxt  = rip_pkg::PH_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      neg_r    <= 1'b0;
      failed_r <= 1'b0;
      phase_r  <= rip_pkg::PH_START;
    end else begin
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      failed_r <= failed_nxt;
      phase_r  <= phase_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back popped an empty queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("back pushed a result into a full queue");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (phase_r == rip_pkg::PH_START) && !failed_r && !neg_r && (acc_r == '0))
    else $error("parse state not cleared after final word");

  a_ok_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_word.ok) |-> (res_word.acc <= 64'sd0))
    else $error("good result with positive accumulator");
`endif

endmodule

// ===== hdl/radix_int64_parser_top.sv =====
// Top level of the radix int64 parser: front, classified queue, back, result queue.
// A final word is stored in the classified queue; the back stage then writes its result into the result queue.
// Throughput: one word per cycle unless a queue is full, set by the combinational digit step in the back stage.
// Words with no character and no end mark are dropped at the front.
// Reset (synchronous, rst_n low) empties both queues, clears the parse state
// and sets the radix to 10.
module radix_int64_parser_top #(
  parameter int unsigned MID_DEPTH = rip_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = rip_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic                push,
  output logic                full,
  input  rip_pkg::in_word_t   in_data,
  input  logic                pop,
  output logic                empty,
  output rip_pkg::out_word_t  out_data
);

  localparam int unsigned MID_W = $bits(rip_pkg::mid_word_t);
  localparam int unsigned RES_W = $bits(rip_pkg::res_word_t);

  rip_pkg::mid_word_t mid_wr_w, mid_rd_w;
  logic [MID_W-1:0]   mid_rdata_w;
  logic               mid_push_w, mid_pop_w, mid_empty_w;
  rip_pkg::res_word_t res_wr_w, res_rd_w;
  logic [RES_W-1:0]   res_rdata_w;
  logic               res_push_w, res_full_w;

  rip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_push  (push),
    .in_word  (in_data),
    .mid_full (full),
    .mid_push (mid_push_w),
    .mid_word (mid_wr_w)
  );

  rip_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push_w),
    .wdata (mid_wr_w),
    .full  (full),
    .pop   (mid_pop_w),
    .rdata (mid_rdata_w),
    .empty (mid_empty_w)
  );

  assign mid_rd_w = rip_pkg::mid_word_t'(mid_rdata_w);

  rip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty_w),
    .mid_word  (mid_rd_w),
    .mid_pop   (mid_pop_w),
    .res_full  (res_full_w),
    .res_push  (res_push_w),
    .res_word  (res_wr_w)
  );

  rip_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push_w),
    .wdata (res_wr_w),
    .full  (res_full_w),
    .pop   (pop),
    .rdata (res_rdata_w),
    .empty (empty)
  );

  assign res_rd_w = rip_pkg::res_word_t'(res_rdata_w);

  // Turn the negative accumulator into the signed result; zero on error
  always_comb begin
    out_data.ok = res_rd_w.ok;
    if (!res_rd_w.ok) begin
      out_data.value = '0;
    end else if (res_rd_w.neg) begin
      out_data.value = res_rd_w.acc;
    end else begin
      out_data.value = -res_rd_w.acc;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for radix_int64_parser_top: directed and random number texts checked by a predictor.
`timescale 1ns / 1ps
module tb;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_WORDS = 1750;
  localparam logic [63:0] TWO63        = 64'h8000_0000_0000_0000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [4:0]         cfg_data;
  logic               push;
  logic               full;
  rip_pkg::in_word_t  in_data;
  logic               pop = 1'b0;
  logic               empty;
  rip_pkg::out_word_t out_data;

  // Predictor state: radix register and the text being parsed
  logic [4:0]         radix_cfg;
  longint             txt_acc;
  bit                 txt_neg;
  rip_pkg::phase_t    txt_phase;
  bit                 txt_failed;

  rip_pkg::out_word_t pending_results[$];
  rip_pkg::out_word_t want;
  logic [7:0]         text_buf[$];
  int                 mismatch_count;
  int                 words_sent;
  int                 idle_cycles;
  int                 pop_hold;
  bit                 burst_mode;

  radix_int64_parser_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_base(logic [4:0] r);
    if (r < rip_pkg::RADIX_MIN) return int'(rip_pkg::RADIX_MIN);
    if (r > rip_pkg::RADIX_MAX) return int'(rip_pkg::RADIX_MAX);
    return int'(r);
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c >= rip_pkg::CHAR_DIG0 && c <= rip_pkg::CHAR_DIG9) begin
      return int'(c - rip_pkg::CHAR_DIG0);
    end
    if (c >= rip_pkg::CHAR_UP_A && c <= rip_pkg::CHAR_UP_F) begin
      return int'(c - rip_pkg::CHAR_UP_A) + 10;
    end
    if (c >= rip_pkg::CHAR_LO_A && c <= rip_pkg::CHAR_LO_F) begin
      return int'(c - rip_pkg::CHAR_LO_A) + 10;
    end
    return -1;
  endfunction

  function automatic void clear_text();
    txt_acc    = 0;
    txt_neg    = 1'b0;
    txt_phase  = rip_pkg::PH_START;
    txt_failed = 1'b0;
  endfunction

  // Gather one character into the negated running value
  function automatic void parse_char(logic [7:0] c);
    int     base;
    int     d;
    longint lim;
    longint grd;
    base = eff_base(radix_cfg);
    if (txt_failed) return;
    if (txt_phase == rip_pkg::PH_START && c == rip_pkg::MINUS_CHAR) begin
      txt_neg   = 1'b1;
      txt_phase = rip_pkg::PH_SIGN;
      return;
    end
    d = digit_value(c);
    if (d < 0 || d >= base) begin
      txt_failed = 1'b1;
      return;
    end
    if (txt_phase != rip_pkg::PH_DIGITS) begin
      txt_acc   = -longint'(d);
      txt_phase = rip_pkg::PH_DIGITS;
      return;
    end
    lim = txt_neg ? rip_pkg::LIMIT_NEG : rip_pkg::LIMIT_POS;
    grd = lim / base;
    // too many digits: the multiply would leave the range
    if (txt_acc < grd) begin
      txt_failed = 1'b1;
      return;
    end
    txt_acc = txt_acc * base;
    if (txt_acc < lim + d) begin
      txt_failed = 1'b1;
      return;
    end
    txt_acc = txt_acc - d;
  endfunction

  // Apply one accepted word; a final word yields one expected result
  function automatic void apply_word(rip_pkg::in_word_t w);
    rip_pkg::out_word_t r;
    if (w.has_char) parse_char(w.char_code);
    if (!w.last) return;
    r.ok    = !txt_failed && (txt_phase == rip_pkg::PH_DIGITS);
    r.value = r.ok ? (txt_neg ? txt_acc : -txt_acc) : 64'sd0;
    pending_results.push_back(r);
    clear_text();
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [4:0] pick_radix();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return rip_pkg::RADIX_MIN;
      3:       return rip_pkg::RADIX_MAX;
      4:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [7:0] char_of_digit(int d);
    if (d < 10) return rip_pkg::CHAR_DIG0 + 8'(d);
    return ($urandom_range(0, 1) ? rip_pkg::CHAR_UP_A : rip_pkg::CHAR_LO_A) + 8'(d - 10);
  endfunction

  function automatic int digit_count(logic [63:0] mag, int base);
    int          n;
    logic [63:0] b;
    n = 0;
    b = 64'(base);
    do begin
      n++;
      mag = mag / b;
    end while (mag != 0);
    return n;
  endfunction

  // Append the digits of a magnitude, most significant first
  function automatic void put_magnitude(logic [63:0] mag, int base, int zeros);
    logic [7:0]  rev[$];
    logic [63:0] b;
    b = 64'(base);
    do begin
      rev.push_back(char_of_digit(int'(mag % b)));
      mag = mag / b;
    end while (mag != 0);
    repeat (zeros) text_buf.push_back(char_of_digit(0));
    while (rev.size() != 0) text_buf.push_back(rev.pop_back());
  endfunction

  // Send one word and wait for it to be taken
  task automatic send_word(logic [7:0] c, logic has, logic fin);
    int                gap;
    rip_pkg::in_word_t w;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.char_code = c;
    w.has_char  = has;
    w.last      = fin;
    push    <= 1'b1;
    in_data <= w;
    do @(negedge clk); while (full);
    @(posedge clk);
    apply_word(w);
    if (has || fin) words_sent++;
  endtask

  // Write the radix once the block has gone quiet
  task automatic write_radix(logic [4:0] r);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_cfg = r;
  endtask

  // Send text_buf; end on the last character or with a separate end word
  task automatic send_text(bit sep_end);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(text_buf[i], 1'b1, !sep_end && (i == n - 1));
    end
    if (sep_end || n == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_random_text();
    int          base;
    int          kind;
    int          n;
    longint      delta;
    logic [63:0] mag;
    base = eff_base(radix_cfg);
    text_buf = {};
    kind = $urandom_range(0, 99);
    if (kind < 92 && $urandom_range(0, 2) == 0) text_buf.push_back(rip_pkg::MINUS_CHAR);
    if (kind < 50) begin
      // well-formed digits, mostly short, some at or past full width
      case ($urandom_range(0, 3))
        0, 1:    n = $urandom_range(1, 4);
        2:       n = $urandom_range(1, digit_count(TWO63, base));
        default: n = digit_count(TWO63, base) + $urandom_range(0, 3);
      endcase
      repeat (n) text_buf.push_back(char_of_digit($urandom_range(0, base - 1)));
    end else if (kind < 70) begin
      // magnitudes around the 64-bit limits, or anywhere in 64 bits
      if ($urandom_range(0, 1)) begin
        delta = longint'($urandom_range(0, 4 * base));
        delta = delta - 2 * base;
        mag   = TWO63 + delta;
      end else begin
        mag = {$urandom, $urandom};
      end
      put_magnitude(mag, base, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    end else if (kind < 92) begin
      // broken text: bad byte, misplaced minus or digit out of radix
      repeat ($urandom_range(0, 5)) begin
        text_buf.push_back(char_of_digit($urandom_range(0, base - 1)));
      end
      case ($urandom_range(0, 2))
        0: text_buf.push_back(8'($urandom_range(0, 255)));
        1: text_buf.push_back(rip_pkg::MINUS_CHAR);
        default: text_buf.push_back(base < 16 ? char_of_digit($urandom_range(base, 15))
                                              : 8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1)) begin
          text_buf.push_back(char_of_digit($urandom_range(0, base - 1)));
        end else begin
          text_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else begin
      // empty text or lone minus
      if ($urandom_range(0, 1)) text_buf.push_back(rip_pkg::MINUS_CHAR);
    end
    send_text($urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_and_sign();
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    send_word(rip_pkg::MINUS_CHAR, 1'b1, 1'b1);
    send_word(rip_pkg::MINUS_CHAR, 1'b1, 1'b0);
    send_word(rip_pkg::CHAR_DIG0, 1'b1, 1'b1);
    send_word(rip_pkg::MINUS_CHAR, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // idle word between texts leaves no trace
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(rip_pkg::CHAR_DIG0 + 8'd7, 1'b1, 1'b1);
  endtask

  task automatic test_bad_digits();
    send_word(rip_pkg::CHAR_UP_A, 1'b1, 1'b0);
    send_word(rip_pkg::CHAR_DIG0 + 8'd5, 1'b1, 1'b1);
    send_word(rip_pkg::CHAR_DIG0 + 8'd1, 1'b1, 1'b0);
    send_word(rip_pkg::MINUS_CHAR, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(rip_pkg::CHAR_DIG0 + 8'd4, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_radix_clamp();
    write_radix(5'd31);
    send_word(rip_pkg::CHAR_LO_F, 1'b1, 1'b0);
    send_word(rip_pkg::CHAR_UP_A, 1'b1, 1'b1);
    write_radix(5'd17);
    send_word(rip_pkg::CHAR_UP_F, 1'b1, 1'b1);
    write_radix(5'd0);
    send_word(rip_pkg::CHAR_DIG0 + 8'd1, 1'b1, 1'b0);
    send_word(rip_pkg::CHAR_DIG0, 1'b1, 1'b1);
    write_radix(5'd1);
    send_word(rip_pkg::CHAR_DIG0 + 8'd2, 1'b1, 1'b1);
    write_radix(rip_pkg::RADIX_MIN);
    send_word(rip_pkg::CHAR_DIG0 + 8'd1, 1'b1, 1'b0);
    send_word(rip_pkg::CHAR_DIG0 + 8'd1, 1'b1, 1'b1);
  endtask

  // New radix applies to the rest of a text already begun
  task automatic test_radix_change();
    write_radix(rip_pkg::RADIX_RESET);
    send_word(rip_pkg::CHAR_DIG0 + 8'd1, 1'b1, 1'b0);
    write_radix(rip_pkg::RADIX_MAX);
    send_word(rip_pkg::CHAR_UP_F, 1'b1, 1'b1);
  endtask

  task automatic test_random_texts();
    int goal;
    int phase_end;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      write_radix(pick_radix());
      burst_mode = ($urandom_range(0, 4) == 0);
      phase_end  = words_sent + $urandom_range(100, 250);
      while (words_sent < phase_end && words_sent < goal) send_random_text();
    end
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  // Compare each popped word with the oldest expectation
  always @(negedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: value %0d ok %0b", out_data.value, out_data.ok);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          mismatch_count++;
        end
        if (out_data.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_data.ok);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a run that makes no progress
  always @(negedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
        $display("radix_int64_parser_top verification failed");
        $finish;
      end
    end
  end

  // Drain results with random stalls
  always @(posedge clk) begin
    if (burst_mode) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    push           = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    words_sent     = 0;
    idle_cycles    = 0;
    pop_hold       = 0;
    burst_mode     = 1'b0;
    radix_cfg      = rip_pkg::RADIX_RESET;
    clear_text();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_sign();
    test_bad_digits();
    test_radix_clamp();
    test_radix_change();
    test_random_texts();

    // Hold input idle and pop freely until everything is back
    push <= 1'b0;
    burst_mode = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radix_int64_parser_top verification clean");
    end else begin
      $display("radix_int64_parser_top verification failed");
    end
    $finish;
  end

endmodule
